// ----- src/imp_pkg.sv -----
// imp_pkg: shared constants, widths, register indexes and helpers for the
// integer max pooling block. No dependencies; used by all but imp_ram.

package imp_pkg;

  localparam int WIDTH_MAX   = 256;
  localparam int HEIGHT_MAX  = 256;
  localparam int WINDOW_MAX  = 4;
  localparam int CHANNEL_MAX = 1024;

  localparam int CW  = $clog2(WIDTH_MAX);
  localparam int RW  = $clog2(HEIGHT_MAX);
  localparam int PW  = (CHANNEL_MAX > 1) ? $clog2(CHANNEL_MAX) : 1;
  localparam int SW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW  = $clog2(WINDOW_MAX + 1);
  localparam int DW  = (CW > RW) ? CW : RW;
  localparam int SH  = DW + 3;
  localparam int RCW = SH + 1;
  localparam int AW  = SW + CW;
  localparam int RAM_DEPTH = 1 << AW;

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;

  localparam logic [DATA_W-1:0] SAMPLE_MIN = 32'h8000_0000;

  localparam logic [8:0]  PLANE_WIDTH_RST   = 9'd2;
  localparam logic [8:0]  PLANE_HEIGHT_RST  = 9'd2;
  localparam logic [2:0]  WINDOW_SIZE_RST   = 3'd2;
  localparam logic [2:0]  STEP_RST          = 3'd2;
  localparam logic [10:0] CHANNEL_COUNT_RST = 11'd1;

  typedef enum logic [2:0] {
    REG_PLANE_WIDTH   = 3'd0,
    REG_PLANE_HEIGHT  = 3'd1,
    REG_WINDOW_SIZE   = 3'd2,
    REG_STEP          = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } reg_idx_t;

  // ceil(2^SH / s); exact floor quotient for operands below 2^DW
  function automatic logic [RCW-1:0] recip(input logic [2:0] s);
    logic [RCW-1:0] r;
    case (s)
      3'd2:    r = RCW'(((1 << SH) + 1) / 2);
      3'd3:    r = RCW'(((1 << SH) + 2) / 3);
      3'd4:    r = RCW'(((1 << SH) + 3) / 4);
      3'd5:    r = RCW'(((1 << SH) + 4) / 5);
      3'd6:    r = RCW'(((1 << SH) + 5) / 6);
      3'd7:    r = RCW'(((1 << SH) + 6) / 7);
      default: r = RCW'(1 << SH);
    endcase
    return r;
  endfunction

endpackage

// ----- src/imp_if.sv -----
// imp_in_if / imp_out_if: valid/ready channels for samples and pooled results.
// Depends on imp_pkg for the data width.

interface imp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [imp_pkg::DATA_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface imp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [imp_pkg::DATA_W-1:0] pooled_max;
  logic                              plane_end;
  logic                              tensor_end;
  modport source (output valid, output pooled_max, output plane_end, output tensor_end,
                  input ready);
  modport sink   (input valid, input pooled_max, input plane_end, input tensor_end,
                  output ready);
endinterface

// ----- src/integer_max_pool_2d.sv -----
// integer_max_pool_2d: streaming 2-D max pooling over signed 32-bit samples.
// Depends on imp_pkg, imp_in_if / imp_out_if and imp_ram.
//
// Usage:
//   in_chan takes one sample per transaction in raster order (plane, row,
//   column). out_chan gives one pooled maximum per completed window, with
//   plane_end on the last window of a plane and tensor_end on the last window
//   of the tensor. Registers are written over the APB-style cfg_ port; the
//   user must write them only while the block is idle, which the block does
//   not enforce; pready is tied high. A sample that completes no window
//   leaves the sequencer idle; one at a window corner off the stride grid
//   passes S_MOD and S_CHK back to idle. One that completes a window passes
//   S_MOD, S_CHK, S_READ, S_DRAIN and S_FIN: the row store has one read port,
//   so the k*k window entries (k = window size) are read one per cycle into
//   a single signed compare unit; the result then enters the output register.
//   in_chan.ready is high only while the sequencer is idle. The output
//   register holds one result; a stalled receiver blocks the sequencer in
//   its last step once the next result is finished, and input waits too.
//   Reset clears counters, sequencer, output valid and loads register
//   defaults; the row store is not cleared.

module integer_max_pool_2d (
  input  logic                              clk,
  input  logic                              rst_n,
  imp_in_if.sink                            in_chan,
  imp_out_if.source                         out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [imp_pkg::PADDR_W-1:0]       cfg_paddr,
  input  logic [imp_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [imp_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CW = imp_pkg::CW;
  localparam int RW = imp_pkg::RW;
  localparam int PW = imp_pkg::PW;
  localparam int SW = imp_pkg::SW;
  localparam int KW = imp_pkg::KW;
  localparam int DW = imp_pkg::DW;
  localparam int SH = imp_pkg::SH;
  localparam int RCW = imp_pkg::RCW;
  localparam int AW = imp_pkg::AW;
  localparam int DATA_W = imp_pkg::DATA_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_CHK   = 6'b000100,
    S_READ  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  // configuration registers
  logic [8:0]  plane_width_r, plane_height_r;
  logic [2:0]  window_size_r, step_r;
  logic [10:0] channel_count_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_width_r   <= imp_pkg::PLANE_WIDTH_RST;
      plane_height_r  <= imp_pkg::PLANE_HEIGHT_RST;
      window_size_r   <= imp_pkg::WINDOW_SIZE_RST;
      step_r          <= imp_pkg::STEP_RST;
      channel_count_r <= imp_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_wr) begin
      case (imp_pkg::reg_idx_t'(cfg_paddr[4:2]))
        imp_pkg::REG_PLANE_WIDTH:   plane_width_r   <= cfg_pwdata[8:0];
        imp_pkg::REG_PLANE_HEIGHT:  plane_height_r  <= cfg_pwdata[8:0];
        imp_pkg::REG_WINDOW_SIZE:   window_size_r   <= cfg_pwdata[2:0];
        imp_pkg::REG_STEP:          step_r          <= cfg_pwdata[2:0];
        imp_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (imp_pkg::reg_idx_t'(cfg_paddr[4:2]))
      imp_pkg::REG_PLANE_WIDTH:   cfg_prdata = DATA_W'(plane_width_r);
      imp_pkg::REG_PLANE_HEIGHT:  cfg_prdata = DATA_W'(plane_height_r);
      imp_pkg::REG_WINDOW_SIZE:   cfg_prdata = DATA_W'(window_size_r);
      imp_pkg::REG_STEP:          cfg_prdata = DATA_W'(step_r);
      imp_pkg::REG_CHANNEL_COUNT: cfg_prdata = DATA_W'(channel_count_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // clamped settings
  logic [CW:0]   w_c;
  logic [RW:0]   h_c;
  logic [KW-1:0] k_c;
  logic [2:0]    s_c;
  logic [PW:0]   c_c;

  always_comb begin
    if (plane_width_r == '0) w_c = (CW+1)'(1);
    else if (32'(plane_width_r) > imp_pkg::WIDTH_MAX) w_c = (CW+1)'(imp_pkg::WIDTH_MAX);
    else w_c = (CW+1)'(plane_width_r);

    if (plane_height_r == '0) h_c = (RW+1)'(1);
    else if (32'(plane_height_r) > imp_pkg::HEIGHT_MAX) h_c = (RW+1)'(imp_pkg::HEIGHT_MAX);
    else h_c = (RW+1)'(plane_height_r);

    if (window_size_r == '0) k_c = KW'(1);
    else if (32'(window_size_r) > imp_pkg::WINDOW_MAX) k_c = KW'(imp_pkg::WINDOW_MAX);
    else k_c = KW'(window_size_r);

    s_c = (step_r == '0) ? 3'd1 : step_r;

    if (channel_count_r == '0) c_c = (PW+1)'(1);
    else if (32'(channel_count_r) > imp_pkg::CHANNEL_MAX) c_c = (PW+1)'(imp_pkg::CHANNEL_MAX);
    else c_c = (PW+1)'(channel_count_r);
  end

  // control and datapath registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [PW-1:0] plane_r, plane_nxt;
  logic [KW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [CW-1:0]     x0_r, x0_nxt;
  logic [RW-1:0]     y0_r, y0_nxt;
  logic [DW-1:0]     qx_r, qx_nxt, qy_r, qy_nxt;
  logic [SW-1:0]     start_slot_r, start_slot_nxt, rd_slot_r, rd_slot_nxt;
  logic              pe_r, pe_nxt, te_r, te_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [DATA_W-1:0] out_max_r, out_max_nxt;
  logic              out_pe_r, out_pe_nxt, out_te_r, out_te_nxt;

  // position bookkeeping for the sample being taken
  logic          in_acc;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [SW-1:0] slot_eff, slot_inc;
  logic [PW-1:0] plane_eff;
  logic [CW:0]   col_p1;
  logic [RW:0]   row_p1;
  logic [PW:0]   plane_p1;
  logic          col_wrap, row_wrap, plane_wrap, win_ok;
  logic [CW-1:0] x0_acc;
  logic [RW-1:0] y0_acc;
  logic          pe_acc;
  logic [SW:0]   k1, cur_slot;
  logic [SW-1:0] start_acc;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    col_eff   = ({1'b0, col_r} >= w_c) ? '0 : col_r;
    row_eff   = ({1'b0, row_r} >= h_c) ? '0 : row_r;
    slot_eff  = ({1'b0, row_r} >= h_c) ? '0 : slot_r;
    plane_eff = ({1'b0, plane_r} >= c_c) ? '0 : plane_r;

    col_p1   = {1'b0, col_eff} + (CW+1)'(1);
    row_p1   = {1'b0, row_eff} + (RW+1)'(1);
    plane_p1 = {1'b0, plane_eff} + (PW+1)'(1);
    col_wrap   = col_p1 >= w_c;
    row_wrap   = row_p1 >= h_c;
    plane_wrap = plane_p1 >= c_c;
    slot_inc   = (slot_eff == SW'(imp_pkg::WINDOW_MAX - 1)) ? '0 : slot_eff + SW'(1);

    win_ok = (row_p1 >= (RW+1)'(k_c)) && (col_p1 >= (CW+1)'(k_c));
    x0_acc = CW'(col_p1 - (CW+1)'(k_c));
    y0_acc = RW'(row_p1 - (RW+1)'(k_c));
    pe_acc = (((CW+2)'(x0_acc) + (CW+2)'(s_c)) > ((CW+2)'(w_c) - (CW+2)'(k_c))) &&
             (((RW+2)'(y0_acc) + (RW+2)'(s_c)) > ((RW+2)'(h_c) - (RW+2)'(k_c)));

    k1       = (SW+1)'(k_c) - (SW+1)'(1);
    cur_slot = {1'b0, slot_eff};
    start_acc = (cur_slot >= k1) ? SW'(cur_slot - k1)
                                 : SW'(cur_slot + (SW+1)'(imp_pkg::WINDOW_MAX) - k1);
  end

  // stride check: quotient by reciprocal, then back-multiply
  logic [DW+RCW-1:0] px, py;
  logic [DW+2:0]     mx, my;
  logic              div_ok;

  always_comb begin
    px = (DW+RCW)'(x0_r) * (DW+RCW)'(imp_pkg::recip(s_c));
    py = (DW+RCW)'(y0_r) * (DW+RCW)'(imp_pkg::recip(s_c));
    mx = (DW+3)'(qx_r) * (DW+3)'(s_c);
    my = (DW+3)'(qy_r) * (DW+3)'(s_c);
    div_ok = (mx == (DW+3)'(x0_r)) && (my == (DW+3)'(y0_r));
  end

  // row store
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CW-1:0]     x_rd;

  assign ram_waddr = {slot_eff, col_eff};
  assign x_rd      = x0_r + CW'(dx_r);
  assign ram_raddr = {rd_slot_r, x_rd};

  imp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (imp_pkg::RAM_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr (ram_waddr),
    .wdata (in_chan.sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    slot_nxt       = slot_r;
    plane_nxt      = plane_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    x0_nxt         = x0_r;
    y0_nxt         = y0_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    start_slot_nxt = start_slot_r;
    rd_slot_nxt    = rd_slot_r;
    pe_nxt         = pe_r;
    te_nxt         = te_r;
    best_nxt       = best_r;
    out_max_nxt    = out_max_r;
    out_pe_nxt     = out_pe_r;
    out_te_nxt     = out_te_r;
    out_valid_nxt  = out_valid_r;
    rd_vld_nxt     = (state_r == S_READ);

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (rd_vld_r && ($signed(ram_rdata) > $signed(best_r))) begin
      best_nxt = ram_rdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          col_nxt   = col_wrap ? '0 : col_p1[CW-1:0];
          row_nxt   = row_eff;
          slot_nxt  = slot_eff;
          plane_nxt = plane_eff;
          if (col_wrap) begin
            row_nxt  = row_wrap ? '0 : row_p1[RW-1:0];
            slot_nxt = row_wrap ? '0 : slot_inc;
            if (row_wrap) begin
              plane_nxt = plane_wrap ? '0 : plane_p1[PW-1:0];
            end
          end
          x0_nxt         = x0_acc;
          y0_nxt         = y0_acc;
          pe_nxt         = pe_acc;
          te_nxt         = pe_acc && (plane_p1 == c_c);
          start_slot_nxt = start_acc;
          if (win_ok) begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        qx_nxt    = DW'(px >> SH);
        qy_nxt    = DW'(py >> SH);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (div_ok) begin
          dx_nxt      = '0;
          dy_nxt      = '0;
          rd_slot_nxt = start_slot_r;
          best_nxt    = imp_pkg::SAMPLE_MIN;
          state_nxt   = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (dx_r == k_c - KW'(1)) begin
          dx_nxt      = '0;
          dy_nxt      = dy_r + KW'(1);
          rd_slot_nxt = (rd_slot_r == SW'(imp_pkg::WINDOW_MAX - 1)) ? '0
                                                                    : rd_slot_r + SW'(1);
          if (dy_r == k_c - KW'(1)) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          dx_nxt = dx_r + KW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = best_r;
          out_pe_nxt    = pe_r;
          out_te_nxt    = te_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      plane_r     <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      slot_r      <= slot_nxt;
      plane_r     <= plane_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x0_r         <= x0_nxt;
    y0_r         <= y0_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    start_slot_r <= start_slot_nxt;
    rd_slot_r    <= rd_slot_nxt;
    pe_r         <= pe_nxt;
    te_r         <= te_nxt;
    best_r       <= best_nxt;
    out_max_r    <= out_max_nxt;
    out_pe_r     <= out_pe_nxt;
    out_te_r     <= out_te_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pooled_max = out_max_r;
  assign out_chan.plane_end  = out_pe_r;
  assign out_chan.tensor_end = out_te_r;

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_chan.ready)) |=> out_valid_r)
    else $error("finished window not loaded into output register");

  a_read_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (dx_r < k_c && dy_r < k_c))
    else $error("window read index beyond window size");

  a_rd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_READ || state_r == S_DRAIN))
    else $error("row store data arrived outside the read phase");

  a_tensor_plane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_te_r) |-> out_pe_r)
    else $error("tensor end without plane end");

endmodule

// ----- src/imp_ram.sv -----
// imp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module imp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
